### design/fur_pkg.sv
package fur_pkg;

  localparam int BufferBytes = 256;

  // request types
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // response codes
  localparam logic [3:0] RC_OK       = 4'd0;
  localparam logic [3:0] RC_LENFAIL  = 4'd1;
  localparam logic [3:0] RC_LENERR   = 4'd2;
  localparam logic [3:0] RC_DATAFAIL = 4'd3;
  localparam logic [3:0] RC_CRCFAIL  = 4'd4;
  localparam logic [3:0] RC_SIZEFAIL = 4'd5;
  localparam logic [3:0] RC_MISMATCH = 4'd6;
  localparam logic [3:0] RC_DONE     = 4'd7;
  localparam logic [3:0] RC_CRCBAD   = 4'd8;
  localparam logic [3:0] RC_WAITTO   = 4'd9;

  // config register indexes
  localparam logic [2:0] CFG_BASE  = 3'd0;
  localparam logic [2:0] CFG_DATA  = 3'd1;
  localparam logic [2:0] CFG_END   = 3'd2;
  localparam logic [2:0] CFG_ABORT = 3'd3;
  localparam logic [2:0] CFG_WAIT  = 3'd4;
  localparam logic [2:0] CFG_HDR   = 3'd5;
  localparam logic [2:0] CFG_PAY   = 3'd6;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // one CRC bit step
  function automatic logic [31:0] crc_bit(input logic [31:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
  endfunction

endpackage

### design/fur_crc.sv
// Bit-serial reflected CRC-32 unit: a byte is XORed in on start, then folded in bit by bit while busy.
module fur_crc import fur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        init,
  input  logic        start,
  input  logic [7:0]  data,
  output logic        busy,
  output logic [31:0] crc
);
  logic [2:0] cnt;

  always_ff @(posedge clk) begin
    if (rst || init) begin
      crc  <= CrcInit;
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      crc  <= crc ^ {24'd0, data};
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      crc <= crc_bit(crc);
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) busy <= 1'b0;
    end
  end
endmodule

### design/firmware_upload_receiver.sv
// Firmware upload receiver.
// s_axis carries requests: tdata = {rx_byte, req_type} padded to 16 bits
// (req_type 0 byte, 1 millisecond tick, 2 start session). m_axis carries
// results: tdata = out_kind, resp_code, flash_address, flash_word,
// session_over, upgrade_good (lowest bit up, 71 bits padded to 72); tlast
// marks the final result of one request.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, the block does not enforce this.
// Each request is decoded as it is accepted; a request yielding a response
// holds ready low until the output register is drained. A completed data
// frame walks its buffer one byte per step through a bit-serial CRC unit,
// one word write issued every four bytes, then the ok response.
// Stalls on m_axis hold the output register and freeze the sequencer.
// Synchronous reset returns to idle with no session; control and config
// registers take reset values, the frame buffer and data-path registers do not.
module firmware_upload_receiver import fur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_type[1:0], rx_byte[9:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // kind, code, addr, word, over, good
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [2:0] PH_IDLE = 3'd0, PH_WAIT = 3'd1, PH_LEN = 3'd2,
                         PH_PAY = 3'd3, PH_CRC = 3'd4, PH_SIZE = 3'd5;
  localparam logic [1:0] SQ_IN = 2'd0, SQ_RD = 2'd1, SQ_CRC = 2'd2,
                         SQ_FIN = 2'd3;

  logic [31:0] base_addr;
  logic [7:0]  data_cmd, end_cmd, abort_cmd;
  logic [15:0] wait_lim, hdr_lim, pay_lim;

  logic [2:0]  phase;
  logic [1:0]  sq;
  logic [31:0] write_address, total_bytes, host_checksum, host_length;
  logic [7:0]  frame_length, bytes_taken, rd_idx;
  logic [15:0] gap_timer, wait_timer;
  logic        command_seen;
  logic [7:0]  mem [BufferBytes];
  logic [7:0]  rd_data;
  logic [31:0] word_acc;
  logic        crc_go, crc_busy, crc_init;
  logic [31:0] crc;
  logic        load_tog, ack_tog;

  logic [1:0]  req_type;
  logic [7:0]  rx_byte;
  assign req_type = s_axis_tdata[1:0];
  assign rx_byte  = s_axis_tdata[9:2];

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !rst && (sq == SQ_IN) && out_free;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // output valid: a result is pending while load and ack toggles differ
  assign m_axis_tvalid = load_tog ^ ack_tog;

  always_ff @(posedge clk) begin
    if (rst) ack_tog <= 1'b0;
    else if (m_axis_tvalid && m_axis_tready) ack_tog <= ~ack_tog;
  end

  fur_crc u_crc (.clk, .rst, .init(crc_init), .start(crc_go), .data(rd_data),
                 .busy(crc_busy), .crc);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= 32'd134234112; data_cmd <= 8'd1; end_cmd <= 8'd2;
      abort_cmd <= 8'd3; wait_lim <= 16'd10000; hdr_lim <= 16'd100;
      pay_lim <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_addr <= cfg_data;
        CFG_DATA:  data_cmd  <= cfg_data[7:0];
        CFG_END:   end_cmd   <= cfg_data[7:0];
        CFG_ABORT: abort_cmd <= cfg_data[7:0];
        CFG_WAIT:  wait_lim  <= cfg_data[15:0];
        CFG_HDR:   hdr_lim   <= cfg_data[15:0];
        CFG_PAY:   pay_lim   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (acc && req_type == REQ_BYTE && phase == PH_PAY) mem[bytes_taken] <= rx_byte;
    rd_data <= mem[rd_idx];
  end

  assign crc_init = acc && req_type == REQ_START;
  assign crc_go   = (sq == SQ_RD);

  // timer selection for ticks
  logic [15:0] tsel, lsel;
  always_comb begin
    tsel = gap_timer; lsel = hdr_lim;
    if (phase == PH_WAIT) begin tsel = wait_timer; lsel = wait_lim; end
    else if (phase == PH_PAY) lsel = pay_lim;
  end
  logic expired;
  assign expired = tsel >= lsel;

  task automatic emit(input logic kind, input logic [3:0] code,
                      input logic [31:0] a, input logic [31:0] w,
                      input logic over, input logic good, input logic last);
    load_tog      <= ~load_tog;
    m_axis_tdata  <= {1'b0, good, over, w, a, code, kind};
    m_axis_tlast  <= last;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; sq <= SQ_IN; load_tog <= 1'b0;
      write_address <= 32'd134234112; total_bytes <= '0;
      frame_length <= '0; bytes_taken <= '0; gap_timer <= '0;
      wait_timer <= '0; command_seen <= 1'b0; host_checksum <= '0;
      host_length <= '0; rd_idx <= '0;
    end else begin
      case (sq)
        SQ_IN: if (acc) begin
          if (req_type == REQ_START) begin
            phase <= PH_WAIT; write_address <= base_addr; total_bytes <= '0;
            frame_length <= '0; bytes_taken <= '0; gap_timer <= '0;
            wait_timer <= '0; command_seen <= 1'b0;
          end else if (req_type == REQ_TICK && phase != PH_IDLE) begin
            if (phase == PH_WAIT) begin
              if (!command_seen) begin
                if (expired) begin
                  emit(1'b0, RC_WAITTO, '0, '0, 1'b1, 1'b0, 1'b1);
                  phase <= PH_IDLE;
                end else wait_timer <= wait_timer + 16'd1;
              end
            end else if (expired) begin
              case (phase)
                PH_LEN: begin
                  phase <= PH_WAIT; emit(1'b0, RC_LENFAIL, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                PH_PAY: begin
                  phase <= PH_WAIT; emit(1'b0, RC_DATAFAIL, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                PH_CRC: begin
                  phase <= PH_IDLE; emit(1'b0, RC_CRCFAIL, '0, '0, 1'b1, 1'b0, 1'b1);
                end
                default: begin
                  phase <= PH_IDLE; emit(1'b0, RC_SIZEFAIL, '0, '0, 1'b1, 1'b0, 1'b1);
                end
              endcase
            end else gap_timer <= gap_timer + 16'd1;
          end else if (req_type == REQ_BYTE && phase != PH_IDLE) begin
            gap_timer <= '0;
            case (phase)
              PH_WAIT: begin
                command_seen <= 1'b1; bytes_taken <= '0;
                if (rx_byte == data_cmd) phase <= PH_LEN;
                else if (rx_byte == end_cmd) phase <= PH_CRC;
                else if (rx_byte == abort_cmd) begin
                  phase <= PH_IDLE; emit(1'b0, RC_OK, '0, '0, 1'b1, 1'b0, 1'b1);
                end
              end
              PH_LEN: begin
                frame_length <= rx_byte; bytes_taken <= '0;
                if (rx_byte == 8'd0 || rx_byte[1:0] != 2'd0) begin
                  phase <= PH_WAIT; emit(1'b0, RC_LENERR, '0, '0, 1'b0, 1'b0, 1'b1);
                end else phase <= PH_PAY;
              end
              PH_PAY: begin
                bytes_taken <= bytes_taken + 8'd1;
                if (bytes_taken + 8'd1 == frame_length) begin
                  rd_idx <= '0; sq <= SQ_RD; bytes_taken <= '0;
                end
              end
              PH_CRC: begin
                host_checksum <= {rx_byte, host_checksum[31:8]};
                bytes_taken <= bytes_taken + 8'd1;
                if (bytes_taken + 8'd1 >= 8'd4) begin
                  bytes_taken <= '0; phase <= PH_SIZE;
                end
              end
              default: begin
                host_length <= {rx_byte, host_length[31:8]};
                bytes_taken <= bytes_taken + 8'd1;
                if (bytes_taken + 8'd1 >= 8'd4) begin
                  bytes_taken <= '0; phase <= PH_IDLE;
                  if (total_bytes != {rx_byte, host_length[31:8]})
                    emit(1'b0, RC_MISMATCH, '0, '0, 1'b1, 1'b0, 1'b1);
                  else if ((crc ^ CrcInit) == host_checksum)
                    emit(1'b0, RC_DONE, '0, '0, 1'b1, 1'b1, 1'b1);
                  else
                    emit(1'b0, RC_CRCBAD, '0, '0, 1'b1, 1'b0, 1'b1);
                end
              end
            endcase
          end
        end
        // rd_data holds the byte at rd_idx; step the index so the next
        // byte is read while the CRC unit works
        SQ_RD: begin
          word_acc <= {rd_data, word_acc[31:8]};
          rd_idx <= rd_idx + 8'd1;
          sq <= SQ_CRC;
        end
        // rd_idx already points past the byte just folded
        SQ_CRC: if (!crc_busy && out_free) begin
          if (rd_idx[1:0] == 2'd0)
            emit(1'b1, RC_OK, write_address + {24'd0, rd_idx - 8'd4},
                 word_acc, 1'b0, 1'b0, 1'b0);
          if (rd_idx == frame_length) sq <= SQ_FIN;
          else sq <= SQ_RD;
        end
        default: if (out_free) begin
          emit(1'b0, RC_OK, '0, '0, 1'b0, 1'b0, 1'b1);
          write_address <= write_address + {24'd0, frame_length};
          total_bytes <= total_bytes + {24'd0, frame_length};
          rd_idx <= '0;
          phase <= PH_WAIT; sq <= SQ_IN;
        end
      endcase
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (sq != SQ_IN) |-> !s_axis_tready) else $error("ready while sequencing");
  a_word_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tlast) else $error("word marked last");
  a_good_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[70]) |-> (m_axis_tdata[4:1] == RC_DONE))
    else $error("good without done");
endmodule
